@@ rtl/quadratic_root_solver_assert.svh @@
// Assertion macros for the quadratic root solver RTL.
// Depends on nothing; included by quadratic_root_solver, the only module with assertions.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define QRS_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define QRS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/qrs_pkg.sv @@
// Package of the quadratic root solver: root-kind and equation-case codes.
// Depends on nothing.
`default_nettype none
package qrs_pkg;
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2,
        KIND_INF  = 2'd3
    } root_kind_t;

    typedef enum logic [1:0] {
        CASE_DEGEN = 2'd0,
        CASE_LIN   = 2'd1,
        CASE_QUAD  = 2'd2
    } eq_case_t;
endpackage
`default_nettype wire

@@ rtl/qrs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, signed truncating.
// Depends on nothing but its parameters.
`default_nettype none
module qrs_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33,
    parameter int Q_W   = 48
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quo
);
    localparam int UN = NUM_W;
    localparam int R_W = DEN_W + 1;

    logic [UN-1:0]    n_reg   [0:UN];
    logic [UN-1:0]    q_reg   [0:UN];
    logic [R_W-1:0]   r_reg   [0:UN];
    logic [DEN_W-1:0] d_reg   [0:UN];
    logic             neg_reg [0:UN];

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]   <= num[NUM_W-1] ? (~num + 1'b1) : num;
            d_reg[0]   <= den[DEN_W-1] ? (~den + 1'b1) : den;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            q_reg[0]   <= '0;
            r_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < UN; i++) begin : g_st
        logic [R_W-1:0] sh;
        logic [R_W:0]   df;
        assign sh = {r_reg[i][R_W-2:0], n_reg[i][UN-1-i]};
        assign df = {1'b0, sh} - {2'b0, d_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i+1]   <= df[R_W] ? sh : df[R_W-1:0];
                q_reg[i+1]   <= {q_reg[i][UN-2:0], ~df[R_W]};
                n_reg[i+1]   <= n_reg[i];
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    logic [UN:0] sq;
    assign sq  = neg_reg[UN] ? (~{1'b0, q_reg[UN]} + 1'b1) : {1'b0, q_reg[UN]};
    assign quo = Q_W'(sq);
endmodule
`default_nettype wire

@@ rtl/qrs_sqrt.sv @@
// Pipelined integer square root, one result bit per stage (floor).
// Depends on nothing but its parameters.
`default_nettype none
module qrs_sqrt #(
    parameter int IN_W = 96
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [IN_W-1:0]   x,
    output logic      [IN_W/2-1:0] root
);
    localparam int R_W = IN_W / 2;
    localparam int M_W = R_W + 2;

    logic [IN_W-1:0] x_reg [0:R_W];
    logic [R_W-1:0]  q_reg [0:R_W];
    logic [M_W-1:0]  m_reg [0:R_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= x;
            q_reg[0] <= '0;
            m_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < R_W; i++) begin : g_st
        logic [M_W-1:0] sh;
        logic [M_W-1:0] tr;
        logic [M_W:0]   df;
        assign sh = {m_reg[i][M_W-3:0], x_reg[i][IN_W-1-2*i -: 2]};
        assign tr = {q_reg[i], 2'b01};
        assign df = {1'b0, sh} - {1'b0, tr};
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[i+1] <= df[M_W] ? sh : df[M_W-1:0];
                q_reg[i+1] <= {q_reg[i][R_W-2:0], ~df[M_W]};
                x_reg[i+1] <= x_reg[i];
            end
        end
    end

    assign root = q_reg[R_W];
endmodule
`default_nettype wire

@@ rtl/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: dividers, discriminant, square root.
// Depends on qrs_pkg, qrs_div, qrs_sqrt and the assertion macro header.
//
// Channel | Dir | tdata fields (low bit up)             | tuser
// s_axis  | in  | coef_a, coef_b, coef_c                | -
// m_axis  | out | root_first, root_second               | root_kind, overflow
//
// The pipeline holds the divider input register and one stage per numerator bit, a
// saturation stage, a discriminant stage, the square root input register and one stage
// per root bit, and the output register.
// One item enters per cycle; the whole pipe advances when the output stage is
// empty or taken, so a stall freezes every stage and nothing is lost.
// Reset clears the valid bits only.
`default_nettype none
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // coef_a, coef_b, coef_c
    input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // root_first, root_second
    output logic [((2*COEF_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // root_kind, overflow
    output logic [7:0]                     m_axis_tuser
);
    import qrs_pkg::*;
    `include "quadratic_root_solver_assert.svh"

    localparam int W    = COEF_WIDTH;
    localparam int NW   = W + FRAC_BITS + 1;
    localparam int DW   = W + 2;
    localparam int DLAT = NW + 1;
    localparam int PW   = 2 * W + 2;
    localparam int SW   = PW + FRAC_BITS + ((PW + FRAC_BITS) % 2);
    localparam int SLAT = SW / 2 + 1;
    localparam int LAT  = DLAT + 2 + SLAT + 1;
    localparam int TDW  = ((2*COEF_WIDTH+7)/8)*8;
    localparam logic signed [W+1:0] VMAX = (W+2)'((64'sd1 <<< (W-1)) - 1);
    localparam logic signed [W+1:0] VMIN = -VMAX - 1;

    logic en;
    logic [LAT-1:0] v_reg;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = v_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    logic signed [W-1:0] a, b, c;
    assign a = s_axis_tdata[W-1:0];
    assign b = s_axis_tdata[2*W-1:W];
    assign c = s_axis_tdata[3*W-1:2*W];

    eq_case_t case_in;
    assign case_in = (a == '0) ? ((b == '0) ? CASE_DEGEN : CASE_LIN) : CASE_QUAD;

    logic [NW-1:0] num1, num2;
    logic [DW-1:0] den1, den2;
    always_comb begin
        if (case_in == CASE_LIN) begin
            num1 = -(NW'(signed'(c)) <<< FRAC_BITS);
            den1 = DW'(signed'(b));
        end else begin
            num1 = NW'(signed'(b)) <<< FRAC_BITS;
            den1 = DW'(signed'(a)) <<< 1;
        end
        num2 = NW'(signed'(c)) <<< FRAC_BITS;
        den2 = DW'(signed'(a));
    end

    logic [NW-1:0] q1, q2;
    qrs_div #(.NUM_W(NW), .DEN_W(DW), .Q_W(NW)) u_div1 (
        .aclk(aclk), .en(en), .num(num1), .den(den1), .quo(q1));
    qrs_div #(.NUM_W(NW), .DEN_W(DW), .Q_W(NW)) u_div2 (
        .aclk(aclk), .en(en), .num(num2), .den(den2), .quo(q2));

    eq_case_t cs_d  [0:DLAT-1];
    logic     cz_d  [0:DLAT-1];
    always_ff @(posedge aclk) begin
        if (en) begin
            cs_d[0] <= case_in;
            cz_d[0] <= (c == '0);
            for (int i = 1; i < DLAT; i++) begin
                cs_d[i] <= cs_d[i-1];
                cz_d[i] <= cz_d[i-1];
            end
        end
    end

    logic signed [W-1:0] p_sat, q_sat;
    logic                p_ovf, q_ovf;
    always_comb begin
        p_ovf = ($signed(q1) > NW'(VMAX)) || ($signed(q1) < NW'(VMIN));
        q_ovf = ($signed(q2) > NW'(VMAX)) || ($signed(q2) < NW'(VMIN));
        p_sat = ($signed(q1) > NW'(VMAX)) ? W'(VMAX) :
                ($signed(q1) < NW'(VMIN)) ? W'(VMIN) : W'(q1);
        q_sat = ($signed(q2) > NW'(VMAX)) ? W'(VMAX) :
                ($signed(q2) < NW'(VMIN)) ? W'(VMIN) : W'(q2);
    end

    logic [W-1:0] mag;
    assign mag = p_sat[W-1] ? W'(-p_sat) : p_sat;

    eq_case_t            cs_p_reg;
    logic                cz_p_reg, ov_p_reg;
    logic signed [W-1:0] p_p_reg, q_p_reg;
    logic [W-1:0]        mag_p_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            cs_p_reg  <= cs_d[DLAT-1];
            cz_p_reg  <= cz_d[DLAT-1];
            p_p_reg   <= p_sat;
            q_p_reg   <= q_sat;
            mag_p_reg <= mag;
            ov_p_reg  <= (cs_d[DLAT-1] == CASE_QUAD) ? (p_ovf || q_ovf) :
                         (cs_d[DLAT-1] == CASE_LIN) ? p_ovf : 1'b0;
        end
    end

    eq_case_t           cs_e_reg;
    logic               cz_e_reg, ov_e_reg;
    logic signed [W-1:0] p_e_reg;
    logic signed [PW-1:0] d_e_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            cs_e_reg <= cs_p_reg;
            cz_e_reg <= cz_p_reg;
            p_e_reg  <= p_p_reg;
            ov_e_reg <= ov_p_reg;
            d_e_reg  <= PW'(({W'(0), mag_p_reg} * {W'(0), mag_p_reg}) >> FRAC_BITS)
                        - PW'(q_p_reg);
        end
    end

    logic [SW-1:0]   sq_in;
    logic [SW/2-1:0] s_root;
    assign sq_in = d_e_reg[PW-1] ? '0 : (SW'(unsigned'(d_e_reg)) << FRAC_BITS);
    qrs_sqrt #(.IN_W(SW)) u_sqrt (.aclk(aclk), .en(en), .x(sq_in), .root(s_root));

    eq_case_t            cs_s [0:SLAT-1];
    logic                cz_s [0:SLAT-1];
    logic                ov_s [0:SLAT-1];
    logic signed [W-1:0] p_s  [0:SLAT-1];
    root_kind_t          dk_s [0:SLAT-1];
    always_ff @(posedge aclk) begin
        if (en) begin
            cs_s[0] <= cs_e_reg;
            cz_s[0] <= cz_e_reg;
            ov_s[0] <= ov_e_reg;
            p_s[0]  <= p_e_reg;
            dk_s[0] <= d_e_reg[PW-1] ? KIND_NONE : ((d_e_reg == '0) ? KIND_ONE : KIND_TWO);
            for (int i = 1; i < SLAT; i++) begin
                cs_s[i] <= cs_s[i-1];
                cz_s[i] <= cz_s[i-1];
                ov_s[i] <= ov_s[i-1];
                p_s[i]  <= p_s[i-1];
                dk_s[i] <= dk_s[i-1];
            end
        end
    end

    eq_case_t            cs_f;
    logic signed [W-1:0] pf;
    logic signed [SW/2+1:0] np, r1w, r2w;
    logic signed [W-1:0] r1, r2;
    logic                o1, o2;
    root_kind_t          kind;
    logic                ovf;
    assign cs_f = cs_s[SLAT-1];
    assign pf   = p_s[SLAT-1];
    assign np   = -(SW/2+2)'(pf);
    assign r1w  = np - (SW/2+2)'(s_root);
    assign r2w  = np + (SW/2+2)'(s_root);
    always_comb begin
        o1 = (r1w > (SW/2+2)'(VMAX)) || (r1w < (SW/2+2)'(VMIN));
        o2 = (r2w > (SW/2+2)'(VMAX)) || (r2w < (SW/2+2)'(VMIN));
        r1 = (r1w > (SW/2+2)'(VMAX)) ? W'(VMAX) :
             (r1w < (SW/2+2)'(VMIN)) ? W'(VMIN) : W'(r1w);
        r2 = (r2w > (SW/2+2)'(VMAX)) ? W'(VMAX) :
             (r2w < (SW/2+2)'(VMIN)) ? W'(VMIN) : W'(r2w);
        kind = KIND_NONE;
        ovf  = 1'b0;
        case (cs_f)
            CASE_DEGEN: kind = cz_s[SLAT-1] ? KIND_INF : KIND_NONE;
            CASE_LIN: begin
                kind = KIND_ONE;
                r1   = pf;
                ovf  = ov_s[SLAT-1];
                r2   = '0;
            end
            CASE_QUAD: begin
                ovf = ov_s[SLAT-1];
                case (dk_s[SLAT-1])
                    KIND_TWO: begin
                        kind = KIND_TWO;
                        ovf  = ov_s[SLAT-1] || o1 || o2;
                    end
                    KIND_ONE: begin
                        kind = KIND_ONE;
                        r2   = '0;
                        ovf  = ov_s[SLAT-1] || o1;
                    end
                    default: kind = KIND_NONE;
                endcase
            end
            default: kind = KIND_NONE;
        endcase
        if (kind == KIND_NONE || kind == KIND_INF) begin
            r1 = '0;
            r2 = '0;
        end
    end

    logic [W-1:0] r1_reg, r2_reg;
    root_kind_t   kind_reg;
    logic         ovf_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg   <= r1;
            r2_reg   <= r2;
            kind_reg <= kind;
            ovf_reg  <= ovf;
        end
    end

    assign m_axis_tdata = TDW'({r2_reg, r1_reg});
    assign m_axis_tuser = {5'b0, ovf_reg, kind_reg};

    `QRS_ASSERT_IMP(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready)
    `QRS_ASSERT_IMP(a_unused_zero, aclk, aresetn,
        m_axis_tvalid && (kind_reg == KIND_NONE || kind_reg == KIND_INF),
        r1_reg == '0 && r2_reg == '0)
    `QRS_ASSERT_NEXT(a_pipe_hold, aclk, aresetn, !en, v_reg == $past(v_reg))
endmodule
`default_nettype wire

@@ dv/quadratic_root_checker.sv @@
// Checker for the quadratic root solver: watches both stream channels,
// predicts each result from the accepted coefficients and compares it.
// Depends on qrs_pkg for the root-kind codes.
module quadratic_root_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [63:0]  m_axis_tdata,
    input  wire logic [7:0]   m_axis_tuser,
    output int                fail_count,
    output int                pending_roots
);
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    typedef struct packed {
        root_kind_t  kind;
        logic [31:0] first;
        logic [31:0] second;
        logic        ovf;
    } roots_t;

    roots_t expected_roots[$];
    bit     sat_hit;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    function automatic longint clamp_q(longint v);
        if (v > QMAX) begin
            sat_hit = 1;
            return QMAX;
        end
        if (v < QMIN) begin
            sat_hit = 1;
            return QMIN;
        end
        return v;
    endfunction

    function automatic longint floor_sqrt(logic [63:0] x);
        logic [63:0] lo, hi, mid;
        lo = '0;
        hi = 64'd4294967296;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= x) lo = mid;
            else hi = mid;
        end
        return longint'(lo);
    endfunction

    function automatic roots_t solve_roots(logic [31:0] ra, logic [31:0] rb,
                                           logic [31:0] rc);
        longint a, b, c, p, q, d, s;
        logic [63:0] mag;
        roots_t r;
        a = longint'(signed'(ra));
        b = longint'(signed'(rb));
        c = longint'(signed'(rc));
        sat_hit = 0;
        r.kind = KIND_NONE;
        r.first = '0;
        r.second = '0;
        if (a == 0 && b == 0) begin
            r.kind = (c == 0) ? KIND_INF : KIND_NONE;
        end else if (a == 0) begin
            r.kind = KIND_ONE;
            r.first = 32'(clamp_q((-(c * 65536)) / b));
        end else begin
            p = clamp_q((b * 65536) / (2 * a));
            q = clamp_q((c * 65536) / a);
            mag = (p < 0) ? -p : p;
            d = longint'((mag * mag) >> 16) - q;
            if (d > 0) begin
                s = floor_sqrt(d << 16);
                r.kind = KIND_TWO;
                r.first = 32'(clamp_q(-p - s));
                r.second = 32'(clamp_q(-p + s));
            end else if (d == 0) begin
                r.kind = KIND_ONE;
                r.first = 32'(clamp_q(-p));
            end
        end
        r.ovf = sat_hit;
        return r;
    endfunction

    assign pending_roots = expected_roots.size();

    always @(posedge aclk) begin
        roots_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_roots.size() == 0) begin
                    $display("%0t: unexpected result %h %h", $time, m_axis_tuser, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_roots.pop_front();
                    if (m_axis_tuser[1:0] !== want.kind || m_axis_tuser[2] !== want.ovf
                            || m_axis_tdata[31:0] !== want.first
                            || m_axis_tdata[63:32] !== want.second) begin
                        $display({"%0t: mismatch expected kind %0d ovf %0d r1 %h r2 %h,",
                                  " got kind %0d ovf %0d r1 %h r2 %h"},
                                 $time, want.kind, want.ovf, want.first, want.second,
                                 m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tdata[31:0],
                                 m_axis_tdata[63:32]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_roots.push_back(solve_roots(s_axis_tdata[31:0],
                                                     s_axis_tdata[63:32], s_axis_tdata[95:64]));
        end
    end
endmodule

@@ dv/testbench.sv @@
// Top of the quadratic root solver testbench: clock, reset, coefficient
// stimulus and the verdict. Depends on quadratic_root_checker and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic [7:0]  m_axis_tuser;
    int          fail_count, pending_roots;
    int          idle_cycles = 0;
    bit          calm = 0;
    int          sent = 0;

    quadratic_root_solver dut (.*);
    quadratic_root_checker checker_i (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge aclk);
            end
            m_axis_tready <= 1;
        end
    end

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3: return 32'($urandom_range(0, 8) - 4) << 16;
            4: return 32'($signed($urandom_range(0, 4095)) - 2048) << 8;
            5: return 32'($urandom_range(0, 511)) - 256;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [95:0] nice_roots_item();
        logic [31:0] a, r1, r2;
        int x1, x2, k;
        k = $urandom_range(1, 4);
        x1 = $urandom_range(0, 40) - 20;
        x2 = ($urandom_range(0, 3) == 0) ? x1 : int'($urandom_range(0, 40)) - 20;
        a = 32'(k) << 16;
        r1 = 32'(-k * (x1 + x2)) << 16;
        r2 = 32'(k * x1 * x2) << 16;
        return {r2, r1, a};
    endfunction

    task automatic send_item(logic [95:0] d);
        int n;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent++;
    endtask

    initial begin
        logic [31:0] edge_vals[5] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h00010000,
                                      32'hffff0000};
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_item({32'h0, 32'h0, 32'h0});
        send_item({32'h00010000, 32'h0, 32'h0});
        send_item({32'h00030000, 32'h00020000, 32'h0});
        send_item({32'h00010000, 32'hfffe0000, 32'h00010000});
        send_item({32'h00010000, 32'h0, 32'h00010000});
        send_item({32'hfffc0000, 32'h0, 32'h00010000});
        send_item({32'h00020000, 32'h00000001, 32'h80000000});
        for (int i = 0; i < 15; i++)
            send_item({edge_vals[$urandom_range(0, 4)], edge_vals[$urandom_range(0, 4)],
                       edge_vals[$urandom_range(0, 4)]});
        s_axis_tvalid <= 0;
        while (pending_roots != 0) @(posedge aclk);
        for (int i = 0; i < 1050; i++) begin
            if (i > 950) calm = 1;
            if ($urandom_range(0, 9) < 6)
                send_item(nice_roots_item());
            else
                send_item({pick_coef(), pick_coef(), pick_coef()});
        end
        s_axis_tvalid <= 0;
        while (pending_roots != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Ran %0d coefficient sets: degenerate, linear, double, distinct", sent);
        $display("and complex roots, extreme and saturating coefficients, random stalls.");
        if (fail_count == 0 && pending_roots == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
